// ----- design/mismatch_path_cost_unit_defines.svh -----
// Assertion macros used by the RTL datapath
`ifndef MISMATCH_PATH_COST_UNIT_DEFINES_SVH
`define MISMATCH_PATH_COST_UNIT_DEFINES_SVH

// clocked check, masked while reset is high
`define MPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define MPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/mpc_pkg.sv -----
package mpc_pkg;

   localparam int MAX_LEN     = 256;
   localparam int SYMBOL_BITS = 21;
   localparam int IN_SYM_BITS = 21;
   localparam int SYM_W       = (SYMBOL_BITS < IN_SYM_BITS) ? SYMBOL_BITS : IN_SYM_BITS;
   localparam int IDX_BITS    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_BITS    = IDX_BITS + 1;
   localparam int COST_BITS   = 9;

   localparam logic [LEN_BITS-1:0]  MAX_LEN_L  = LEN_BITS'(MAX_LEN);
   localparam logic [COST_BITS-1:0] COST_MAX   = '1;

   localparam logic OP_REF    = 1'b0;
   localparam logic OP_STREAM = 1'b1;

   typedef struct packed {
      logic                   opcode;
      logic [IN_SYM_BITS-1:0] symbol;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] score;
      logic                 error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                accept;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_idx;
      logic                load_rsp;
      logic                rsp_err;
   } dp_cmd_type;

   typedef struct packed {
      logic                b_ok;
      logic [IDX_BITS-1:0] last_idx;
      logic                rsp_free;
   } dp_status_type;

endpackage

// ----- design/mismatch_path_cost_unit.sv -----
// Least-cost mismatch path between a loaded reference string A and a streamed string B.
// Input transactions (req_valid/req_stall, req_data): opcode 0 appends a symbol to A,
// opcode 1 streams a symbol of B; last marks the end of either string.
// One result transaction (rsp_valid/rsp_stall, rsp_data) follows each B symbol with last
// set: the path cost, or score 0 with error set if A was empty, incomplete or too long,
// or B ran past capacity. A stays loaded for the next B.
// An A symbol leaves the block idle for the next transaction. A scored B symbol walks
// the grid column one cell a cycle through the reference and cost RAMs (SCAN, then
// DRAIN) before the next transaction is taken; the result register loads in EMIT,
// after the walk. Unscored B symbols skip the walk; with last set they go to EMIT.
// req_stall is high while a column walk or a result hand-off is in progress.
// If rsp_stall holds the previous result, the block waits before loading the next.
// Reset (synchronous) empties A, clears the B count and drops any pending result; RAM
// contents are not cleared and are never read before being written.
module mismatch_path_cost_unit
   import mpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ----- design/mpc_ram.sv -----
module mpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- design/mpc_ctrl.sv -----
module mpc_ctrl
   import mpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                err_ff, err_in;
   logic                last_ff, last_in;
   logic                accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      err_in    = err_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            if (accept && req_data.opcode == OP_STREAM) begin
               err_in  = !status.b_ok;
               last_in = req_data.last;
               if (status.b_ok) begin
                  state_in = ST_SCAN;
               end else if (req_data.last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == status.last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd.accept   = accept;
      cmd.rd_en    = (state_ff == ST_SCAN);
      cmd.rd_idx   = rd_idx_ff;
      cmd.load_rsp = (state_ff == ST_EMIT) && status.rsp_free;
      cmd.rsp_err  = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
         err_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         err_ff    <= err_in;
         last_ff   <= last_in;
      end
   end

endmodule

// ----- design/mpc_datapath.sv -----
`include "mismatch_path_cost_unit_defines.svh"

module mpc_datapath
   import mpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          rsp_stall
);

   logic [LEN_BITS-1:0]  ref_len_ff, ref_len_in;
   logic [LEN_BITS-1:0]  cmp_cnt_ff, cmp_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 done_ff, done_in;
   logic [SYM_W-1:0]     sym_ff;
   logic                 col_zero_ff;
   logic                 wr_vld_ff;
   logic [IDX_BITS-1:0]  wr_idx_ff;
   logic [COST_BITS-1:0] diag_ff, up_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [LEN_BITS-1:0]  len_eff;
   logic                 ref_wr;
   logic [SYM_W-1:0]     in_sym;
   logic [SYM_W-1:0]     ref_rd;
   logic [COST_BITS-1:0] col_rd;
   logic                 mis;
   logic [COST_BITS-1:0] m_val;
   logic [COST_BITS:0]   sum;
   logic [COST_BITS-1:0] val;

   assign in_sym  = req_data.symbol[SYM_W-1:0];
   assign len_eff = done_ff ? '0 : ref_len_ff;
   assign ref_wr  = cmd.accept && (req_data.opcode == OP_REF) && (len_eff < MAX_LEN_L);

   mpc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_wr),
      .wr_addr (len_eff[IDX_BITS-1:0]),
      .wr_data (in_sym),
      .rd_addr (cmd.rd_idx),
      .rd_data (ref_rd)
   );

   mpc_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_LEN)) u_col_ram (
      .clock   (clock),
      .wr_en   (wr_vld_ff),
      .wr_addr (wr_idx_ff),
      .wr_data (val),
      .rd_addr (cmd.rd_idx),
      .rd_data (col_rd)
   );

   // one grid cell per cycle: diag is the old cost one row up, up is the new one
   always_comb begin
      mis   = (ref_rd != sym_ff);
      m_val = col_rd;
      if (wr_idx_ff != '0) begin
         if (diag_ff < m_val) m_val = diag_ff;
         if (up_ff < m_val)   m_val = up_ff;
      end
      if (col_zero_ff) begin
         sum = (wr_idx_ff == '0) ? (COST_BITS+1)'(1) : ({1'b0, up_ff} + (COST_BITS+1)'(mis));
      end else begin
         sum = {1'b0, m_val} + (COST_BITS+1)'(mis);
      end
      val = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
   end

   always_comb begin
      ref_len_in = ref_len_ff;
      cmp_cnt_in = cmp_cnt_ff;
      ovf_in     = ovf_ff;
      done_in    = done_ff;
      if (cmd.accept) begin
         if (req_data.opcode == OP_REF) begin
            cmp_cnt_in = '0;
            ovf_in     = done_ff ? 1'b0 : ovf_ff;
            if (len_eff < MAX_LEN_L) begin
               ref_len_in = len_eff + 1'b1;
            end else begin
               ref_len_in = len_eff;
               ovf_in     = 1'b1;
            end
            done_in = req_data.last;
         end else if (req_data.last) begin
            cmp_cnt_in = '0;
         end else if (cmp_cnt_ff <= MAX_LEN_L) begin
            cmp_cnt_in = cmp_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      status.b_ok     = done_ff && !ovf_ff && (ref_len_ff != '0) && (cmp_cnt_ff < MAX_LEN_L);
      status.last_idx = IDX_BITS'(ref_len_ff - 1'b1);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         cmp_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_len_ff <= ref_len_in;
         cmp_cnt_ff <= cmp_cnt_in;
         ovf_ff     <= ovf_in;
         done_ff    <= done_in;
         wr_vld_ff  <= cmd.rd_en;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff <= cmd.rd_idx;
      if (cmd.accept && req_data.opcode == OP_STREAM) begin
         sym_ff      <= in_sym;
         col_zero_ff <= (cmp_cnt_ff == '0);
      end
      if (wr_vld_ff) begin
         diag_ff <= col_rd;
         up_ff   <= val;
      end
      if (cmd.load_rsp) begin
         rsp_ff.score <= cmd.rsp_err ? '0 : up_ff;
         rsp_ff.error <= cmd.rsp_err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MPC_ASSERT(a_no_overwrite, cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall), "result overwritten")
   `MPC_ASSERT(a_len_bound, ref_len_ff <= MAX_LEN_L, "reference length out of range")
   `MPC_ASSERT(a_cmp_bound, cmp_cnt_ff <= MAX_LEN_L + 1'b1, "compare count out of range")
   `MPC_ASSERT(a_rd_in_ref, cmd.rd_en |-> ({1'b0, cmd.rd_idx} < ref_len_ff), "scan past reference")
   `MPC_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

// ----- tb/mismatch_path_cost_checker.sv -----
module mismatch_path_cost_checker
   import mpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   input  logic    req_stall,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    rsp_stall,
   output int      failures,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SYM_W-1:0]     ref_syms [MAX_LEN];
   logic [COST_BITS-1:0] costs [MAX_LEN];
   int                   ref_len;
   int                   col_count;
   bit                   ref_overflow;
   bit                   ref_complete;
   rsp_type              score_q [$];

   // one grid column per B symbol; min of left, diagonal and up plus mismatch (column 0: up plus mismatch, 1 in row 0)
   function void advance_column(int col, logic [SYM_W-1:0] sym);
      int diag, up, left, best, cost;
      diag = 0;
      up   = 0;
      for (int i = 0; i < ref_len; i++) begin
         if (col == 0) begin
            cost = (i == 0) ? 1 : up + (ref_syms[i] != sym);
         end else begin
            left = costs[i];
            best = left;
            if (i > 0) begin
               if (diag < best) best = diag;
               if (up < best) best = up;
            end
            cost = best + (ref_syms[i] != sym);
            diag = left;
         end
         if (cost > int'(COST_MAX)) cost = int'(COST_MAX);
         costs[i] = COST_BITS'(cost);
         up = cost;
      end
   endfunction

   function void predict(req_type txn);
      logic [SYM_W-1:0] sym;
      rsp_type          exp_rsp;
      int               col;
      bit               scored;
      sym = txn.symbol[SYM_W-1:0];
      if (txn.opcode == OP_REF) begin
         if (ref_complete) begin
            ref_len      = 0;
            ref_overflow = 0;
            ref_complete = 0;
         end
         col_count = 0;
         if (ref_len < MAX_LEN) begin
            ref_syms[ref_len] = sym;
            ref_len++;
         end else begin
            ref_overflow = 1;
         end
         if (txn.last) ref_complete = 1;
      end else begin
         col = col_count;
         if (col_count <= MAX_LEN) col_count++;
         scored = ref_complete && !ref_overflow && ref_len > 0 && col < MAX_LEN;
         if (scored) advance_column(col, sym);
         if (txn.last) begin
            exp_rsp.score = scored ? costs[ref_len-1] : '0;
            exp_rsp.error = !scored;
            score_q.push_back(exp_rsp);
            col_count = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         ref_len      = 0;
         col_count    = 0;
         ref_overflow = 0;
         ref_complete = 0;
         score_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               $display("%0t: unexpected result transaction score=%0d error=%0b",
                        $time, rsp_data.score, rsp_data.error);
               failures++;
            end else begin
               exp_rsp = score_q.pop_front();
               if (rsp_data.score !== exp_rsp.score) begin
                  $display("%0t: score mismatch expected %0d actual %0d",
                           $time, exp_rsp.score, rsp_data.score);
                  failures++;
               end
               if (rsp_data.error !== exp_rsp.error) begin
                  $display("%0t: error flag mismatch expected %0b actual %0b",
                           $time, exp_rsp.error, rsp_data.error);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) predict(req_data);
      end
      pending = score_q.size();
   end

   final begin
   end

endmodule

// ----- tb/mismatch_path_cost_unit_tb.sv -----
module mismatch_path_cost_unit_tb;
   import mpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int HOLD_CYCLES = 600;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 0;

   int      failures;
   int      pending;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_request = 0;
   int      hold_left = 0;
   bit      hold_done = 0;
   int      cycles = 0;
   int      sent = 0;
   logic [IN_SYM_BITS-1:0] alphabet [4];

   mismatch_path_cost_unit i_dut (
      .clock, .reset, .req_valid, .req_data, .req_stall,
      .rsp_valid, .rsp_data, .rsp_stall
   );

   mismatch_path_cost_checker i_checker (
      .clock, .reset, .req_valid, .req_data, .req_stall,
      .rsp_valid, .rsp_data, .rsp_stall, .failures, .pending
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send(logic op, logic [IN_SYM_BITS-1:0] sym, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.opcode <= op;
      req_data.symbol <= sym;
      req_data.last   <= last;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   function automatic logic [IN_SYM_BITS-1:0] pick_symbol();
      if ($urandom_range(9) == 0) return IN_SYM_BITS'($urandom);
      return alphabet[$urandom_range(3)];
   endfunction

   task automatic new_alphabet();
      foreach (alphabet[k]) alphabet[k] = IN_SYM_BITS'($urandom);
      if ($urandom_range(3) == 0) alphabet[0] = '1;
      if ($urandom_range(3) == 0) alphabet[1] = '0;
   endtask

   task automatic load_ref(int len);
      for (int k = 0; k < len; k++) send(OP_REF, pick_symbol(), k == len - 1);
   endtask

   task automatic stream_b(int len);
      for (int k = 0; k < len; k++) send(OP_STREAM, pick_symbol(), k == len - 1);
   endtask

   function automatic int rand_len();
      int r;
      r = $urandom_range(99);
      if (r == 0) return MAX_LEN;
      if (r == 1) return MAX_LEN + 1 + $urandom_range(2);
      if (r < 10) return $urandom_range(9, 40);
      return $urandom_range(1, 8);
   endfunction

   // the checker counts the last accepted transaction at the same edge, so let it settle before reading pending
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(int items);
      int stop_at;
      stop_at = sent + items;
      while (sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(2) == 0 || sent == 0) begin
               new_alphabet();
               load_ref(rand_len());
            end
            stream_b(rand_len());
         end else begin
            send(logic'($urandom_range(1)), pick_symbol(), logic'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      new_alphabet();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: B with no reference loaded
      send(OP_STREAM, '0, 1'b1);
      send(OP_REF, '1, 1'b1);
      send(OP_STREAM, '1, 1'b1);
      send(OP_STREAM, '0, 1'b1);
      // short strings, matching and not
      send(OP_REF, 21'h1, 1'b0);
      send(OP_REF, 21'h2, 1'b0);
      send(OP_REF, 21'h1, 1'b1);
      send(OP_STREAM, 21'h1, 1'b0);
      send(OP_STREAM, 21'h2, 1'b0);
      send(OP_STREAM, 21'h1, 1'b1);
      send(OP_STREAM, 21'h155555, 1'b0);
      send(OP_STREAM, 21'h0AAAAA, 1'b1);
      // reference symbol abandons a partly streamed B
      send(OP_STREAM, 21'h1, 1'b0);
      send(OP_REF, 21'h7, 1'b1);
      send(OP_STREAM, 21'h7, 1'b1);
      // incomplete reference
      send(OP_REF, 21'h3, 1'b0);
      send(OP_STREAM, 21'h3, 1'b1);
      send(OP_REF, 21'h3, 1'b1);
      send(OP_STREAM, 21'h3, 1'b1);
      // overlong reference, then reference and B at full capacity
      load_ref(MAX_LEN + 1);
      stream_b(2);
      load_ref(MAX_LEN);
      stream_b(MAX_LEN);
      // overlong B
      load_ref(2);
      stream_b(MAX_LEN + 2);
      stream_b(1);
      drain();

      send_idle_pct = 8;
      recv_idle_pct = 64;
      hold_request  = 1;
      random_phase(120);
      drain();
      repeat (4) @(posedge clock);

      send_idle_pct = 64;
      recv_idle_pct = 8;
      random_phase(120);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(120);
      drain();

      repeat (600) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
